### rtl/rtcep_pkg.sv
// ---------------------------------------------------------------------------
// RTC to epoch seconds package
// Shared types, constants and the month table for the conversion pipeline.
// ---------------------------------------------------------------------------
package rtcep_pkg;

  localparam logic [14:0] EPOCH_YEAR   = 15'd1970;
  localparam logic [14:0] END_YEAR     = 15'd2099;
  localparam logic [14:0] BASE_YEAR    = 15'd2000;
  localparam logic [14:0] MAX_YEAR     = 15'd9999;
  localparam logic [31:0] SECS_PER_DAY = 32'd86400;
  localparam logic [16:0] SECS_PER_HR  = 17'd3600;
  localparam logic [16:0] SECS_PER_MIN = 17'd60;
  localparam logic [15:0] DAYS_PER_YR  = 16'd365;

  typedef enum logic [1:0] {
    CFG_BINARY_MODE     = 2'd0,
    CFG_HOUR_24_MODE    = 2'd1,
    CFG_CENTURY_PRESENT = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic binary_mode;
    logic hour_24_mode;
    logic century_present;
  } cfg_t;

  typedef struct packed {
    logic [7:0] seconds_raw;
    logic [7:0] minutes_raw;
    logic [7:0] hours_raw;
    logic [7:0] day_raw;
    logic [7:0] month_raw;
    logic [7:0] year_raw;
    logic [7:0] century_raw;
  } raw_t;

  typedef struct packed {
    logic [5:0] seconds;
    logic [5:0] minutes;
    logic [4:0] hours;
    logic [4:0] day;
    logic [3:0] month;
  } fields_t;

  typedef struct packed {
    fields_t     f;
    logic [14:0] year;
  } dec_t;

  typedef struct packed {
    fields_t     f;
    logic [13:0] year_out;
    logic [15:0] days;
    logic [16:0] tod;
    logic        out_of_range;
  } cnt_t;

  typedef struct packed {
    fields_t     f;
    logic [13:0] year_out;
    logic [31:0] epoch_seconds;
    logic        out_of_range;
  } res_t;

  // Days in the year before the first of the given month (non-leap).
  function automatic logic [15:0] days_before_month(input logic [3:0] month);
    logic [15:0] r;
    case (month)
      4'd1:    r = 16'd0;
      4'd2:    r = 16'd31;
      4'd3:    r = 16'd59;
      4'd4:    r = 16'd90;
      4'd5:    r = 16'd120;
      4'd6:    r = 16'd151;
      4'd7:    r = 16'd181;
      4'd8:    r = 16'd212;
      4'd9:    r = 16'd243;
      4'd10:   r = 16'd273;
      4'd11:   r = 16'd304;
      4'd12:   r = 16'd334;
      default: r = 16'd0;
    endcase
    return r;
  endfunction

endpackage

### rtl/rtcep_decode.sv
// ---------------------------------------------------------------------------
// RTC field decode stage
// BCD and 12-hour decode, field saturation and full year, one register.
// ---------------------------------------------------------------------------
module rtcep_decode (
  input  logic            clk,
  input  logic            rst,
  input  rtcep_pkg::cfg_t cfg,
  input  logic            in_valid,
  output logic            in_ready,
  input  rtcep_pkg::raw_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output rtcep_pkg::dec_t out_data
);

  function automatic logic [7:0] bcd(input logic [7:0] b);
    return 8'(b[3:0]) + 8'(b[7:4]) * 8'd10;
  endfunction

  logic            valid;
  rtcep_pkg::dec_t data;
  rtcep_pkg::dec_t data_next;
  logic [7:0]      s, m, h, d, n, yb, c;
  logic            pm;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_data  = data;

  always_comb begin
    pm = in_data.hours_raw[7];
    if (cfg.binary_mode) begin
      s  = in_data.seconds_raw;
      m  = in_data.minutes_raw;
      d  = in_data.day_raw;
      n  = in_data.month_raw;
      yb = in_data.year_raw;
      c  = in_data.century_raw;
      h  = cfg.hour_24_mode ? in_data.hours_raw : {1'b0, in_data.hours_raw[6:0]};
    end else begin
      s  = bcd(in_data.seconds_raw);
      m  = bcd(in_data.minutes_raw);
      d  = bcd(in_data.day_raw);
      n  = bcd(in_data.month_raw);
      yb = bcd(in_data.year_raw);
      c  = bcd(in_data.century_raw);
      h  = bcd({1'b0, in_data.hours_raw[6:0]});
      // In 24-hour BCD mode a set top bit still weighs 128, so it saturates.
      if (cfg.hour_24_mode && pm) h = h + 8'h80;
    end
    if (!cfg.hour_24_mode) begin
      if (h == 8'd12) h = 8'd0;
      if (pm) h = h + 8'd12;
    end

    data_next.f.seconds = (s > 8'd59) ? 6'd59 : s[5:0];
    data_next.f.minutes = (m > 8'd59) ? 6'd59 : m[5:0];
    data_next.f.hours   = (h > 8'd23) ? 5'd23 : h[4:0];
    data_next.f.day     = (d == 8'd0) ? 5'd1 : ((d > 8'd31) ? 5'd31 : d[4:0]);
    data_next.f.month   = (n == 8'd0) ? 4'd1 : ((n > 8'd12) ? 4'd12 : n[3:0]);
    data_next.year      = cfg.century_present ? (15'(c) * 15'd100 + 15'(yb))
                                              : (rtcep_pkg::BASE_YEAR + 15'(yb));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data <= data_next;
    end
  end

endmodule

### rtl/rtcep_days.sv
// ---------------------------------------------------------------------------
// RTC day count stage
// Range flag, day number since 1970 and seconds of the day, one register.
// ---------------------------------------------------------------------------
module rtcep_days (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  rtcep_pkg::dec_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output rtcep_pkg::cnt_t out_data
);

  logic            valid;
  rtcep_pkg::cnt_t data;
  rtcep_pkg::cnt_t data_next;
  logic [7:0]      yo;
  logic            leap_adj;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_data  = data;

  always_comb begin
    // Only meaningful while the year is in range; the epoch is masked otherwise.
    yo       = 8'(in_data.year - rtcep_pkg::EPOCH_YEAR);
    leap_adj = (in_data.year[1:0] == 2'd0) && (in_data.f.month > 4'd2);

    data_next.f            = in_data.f;
    data_next.out_of_range = (in_data.year < rtcep_pkg::EPOCH_YEAR) ||
                             (in_data.year > rtcep_pkg::END_YEAR);
    data_next.year_out     = (in_data.year > rtcep_pkg::MAX_YEAR) ?
                             rtcep_pkg::MAX_YEAR[13:0] : in_data.year[13:0];
    data_next.days         = 16'(yo) * rtcep_pkg::DAYS_PER_YR
                           + 16'((yo + 8'd1) >> 2)
                           + rtcep_pkg::days_before_month(in_data.f.month)
                           + 16'(leap_adj)
                           + 16'(in_data.f.day) - 16'd1;
    data_next.tod          = 17'(in_data.f.hours) * rtcep_pkg::SECS_PER_HR
                           + 17'(in_data.f.minutes) * rtcep_pkg::SECS_PER_MIN
                           + 17'(in_data.f.seconds);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data <= data_next;
    end
  end

endmodule

### rtl/rtcep_epoch.sv
// ---------------------------------------------------------------------------
// RTC epoch stage
// Day number times seconds per day plus seconds of the day, output register.
// ---------------------------------------------------------------------------
module rtcep_epoch (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  rtcep_pkg::cnt_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output rtcep_pkg::res_t out_data
);

  logic            valid;
  rtcep_pkg::res_t data;
  rtcep_pkg::res_t data_next;
  logic [31:0]     secs;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_data  = data;

  always_comb begin
    secs = 32'(in_data.days) * rtcep_pkg::SECS_PER_DAY + 32'(in_data.tod);
    data_next.f             = in_data.f;
    data_next.year_out      = in_data.year_out;
    data_next.out_of_range  = in_data.out_of_range;
    data_next.epoch_seconds = in_data.out_of_range ? 32'd0 : secs;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data <= data_next;
    end
  end

endmodule

### rtl/rtc_fields_to_epoch_seconds_top.sv
// ---------------------------------------------------------------------------
// RTC fields to epoch seconds
// Converts one snapshot of raw RTC bytes into calendar fields and Unix time.
//
//   channel  direction  beat contents
//   s_axis   in         tdata: seconds, minutes, hours, day, month, year,
//                              century raw bytes
//   m_axis   out        tdata: decoded fields and epoch seconds;
//                       tuser: out_of_range
//   cfg      in         cfg_we, cfg_index, cfg_data: mode register write
//
// One beat is taken every cycle unless back-pressure has filled every stage.
// The three stages are decode, day count and the day-to-seconds multiply.
// Reset clears the stage valid bits and restores the mode registers.
// Back-pressure stalls each full stage in place; empty stages keep filling.
// ---------------------------------------------------------------------------
module rtc_fields_to_epoch_seconds_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic        cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // seconds_raw, minutes_raw, hours_raw, day_raw, month_raw, year_raw, century_raw
  input  logic [55:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // seconds_out, minutes_out, hours_out, day_out, month_out, year_out, epoch_seconds
  output logic [71:0] m_axis_tdata,
  // out_of_range
  output logic        m_axis_tuser
);

  rtcep_pkg::cfg_t cfg;
  rtcep_pkg::raw_t raw;
  rtcep_pkg::dec_t dec_data;
  rtcep_pkg::cnt_t cnt_data;
  rtcep_pkg::res_t res;
  logic            dec_valid, dec_ready;
  logic            cnt_valid, cnt_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.binary_mode     <= 1'b0;
      cfg.hour_24_mode    <= 1'b1;
      cfg.century_present <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        rtcep_pkg::CFG_BINARY_MODE:     cfg.binary_mode     <= cfg_data;
        rtcep_pkg::CFG_HOUR_24_MODE:    cfg.hour_24_mode    <= cfg_data;
        rtcep_pkg::CFG_CENTURY_PRESENT: cfg.century_present <= cfg_data;
        default: ;
      endcase
    end
  end

  assign raw.seconds_raw = s_axis_tdata[7:0];
  assign raw.minutes_raw = s_axis_tdata[15:8];
  assign raw.hours_raw   = s_axis_tdata[23:16];
  assign raw.day_raw     = s_axis_tdata[31:24];
  assign raw.month_raw   = s_axis_tdata[39:32];
  assign raw.year_raw    = s_axis_tdata[47:40];
  assign raw.century_raw = s_axis_tdata[55:48];

  rtcep_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_data   (raw),
    .out_valid (dec_valid),
    .out_ready (dec_ready),
    .out_data  (dec_data)
  );

  rtcep_days u_days (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (dec_valid),
    .in_ready  (dec_ready),
    .in_data   (dec_data),
    .out_valid (cnt_valid),
    .out_ready (cnt_ready),
    .out_data  (cnt_data)
  );

  rtcep_epoch u_epoch (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cnt_valid),
    .in_ready  (cnt_ready),
    .in_data   (cnt_data),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (res)
  );

  assign m_axis_tdata = {res.epoch_seconds, res.year_out, res.f.month, res.f.day,
                         res.f.hours, res.f.minutes, res.f.seconds};
  assign m_axis_tuser = res.out_of_range;

  // A flagged year never carries a time value.
  a_flag_zero_epoch: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> res.epoch_seconds == 32'd0)
    else $error("flagged beat carries nonzero epoch");

  // An unflagged beat always has a year inside the supported span.
  a_year_span: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |->
      (res.year_out >= 14'd1970) && (res.year_out <= 14'd2099))
    else $error("unflagged beat with year outside span");

  // Saturation keeps calendar fields inside their ranges.
  a_field_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (res.f.hours <= 5'd23) && (res.f.day != 5'd0) &&
      (res.f.month != 4'd0) && (res.f.month <= 4'd12))
    else $error("decoded field out of range");

  // The input side only stalls when the whole pipeline is full and blocked.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready && dec_valid && cnt_valid)
    else $error("input stalled without downstream back-pressure");

endmodule
